/* rtl/encp_pkg.sv */
// Package: shared types and constants of the encoder PID drive balancer.
`timescale 1ns / 1ps
`default_nettype none
package encp_pkg;

	// request operation codes
	typedef enum logic [1:0] {
		OP_RIGHT_EDGE = 2'd0,
		OP_LEFT_EDGE  = 2'd1,
		OP_TICK       = 2'd2
	} op_t;

	// configuration register indexes
	localparam logic [7:0] REG_KP   = 8'd0;
	localparam logic [7:0] REG_KI   = 8'd1;
	localparam logic [7:0] REG_KD   = 8'd2;
	localparam logic [7:0] REG_BASE = 8'd3;

	// configuration reset values
	localparam logic [15:0] KP_RESET   = 16'd154;
	localparam logic [15:0] KI_RESET   = 16'd0;
	localparam logic [15:0] KD_RESET   = 16'd0;
	localparam logic [7:0]  BASE_RESET = 8'd80;

	localparam int ERR_W     = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W    = $clog2(QUEUE_DEPTH);

	localparam logic signed [ERR_W-1:0] ERR_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [ERR_W-1:0] ERR_MIN = 32'sh8000_0000;

endpackage
`default_nettype wire

/* rtl/encp_if.sv */
// Interfaces: request, response and configuration channels.
`timescale 1ns / 1ps
`default_nettype none
interface encp_req_if import encp_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic       phase_b;
	modport source (output valid, output operation, output phase_b, input ready);
	modport sink   (input valid, input operation, input phase_b, output ready);
endinterface

interface encp_rsp_if import encp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [7:0]        right_drive;
	logic [7:0]        left_drive;
	logic signed [31:0] count_difference;
	modport source (output valid, output right_drive, output left_drive,
		output count_difference, input ready);
	modport sink   (input valid, input right_drive, input left_drive,
		input count_difference, output ready);
endinterface

interface encp_cfg_if import encp_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/encoder_pid_differential_drive_core.sv */
// Top level: encoder counting front, error queue, PID back end, registers.
//
//  channel | dir | payload
//  req     | in  | operation[1:0], phase_b
//  rsp     | out | right_drive[7:0], left_drive[7:0], count_difference[31:0]
//  cfg     | in  | index[7:0], data[15:0]
//
// One request per cycle; a tick's error goes through the queue and back end pipeline to rsp.
// Every request, edge or tick, waits while the four-entry error queue is full.
// The back end pipeline holds while a response is not taken.
// Reset clears counters, integral, last error and loads default gains and base.
`timescale 1ns / 1ps
`default_nettype none
module encoder_pid_differential_drive_core import encp_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	encp_req_if.sink    req,
	encp_rsp_if.source  rsp,
	encp_cfg_if.sink    cfg
);

	logic                    q_full;
	logic                    q_empty;
	logic                    q_push;
	logic                    q_pop;
	logic signed [ERR_W-1:0] push_err;
	logic signed [ERR_W-1:0] head_err;
	logic [15:0]             kp_q;
	logic [15:0]             ki_q;
	logic [15:0]             kd_q;
	logic [7:0]              base_q;

	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= KP_RESET;
			ki_q   <= KI_RESET;
			kd_q   <= KD_RESET;
			base_q <= BASE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_KP:   kp_q   <= cfg.data;
				REG_KI:   ki_q   <= cfg.data;
				REG_KD:   kd_q   <= cfg.data;
				REG_BASE: base_q <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	encp_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_full (q_full),
		.q_push (q_push),
		.q_err  (push_err)
	);

	encp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_err (push_err),
		.pop      (q_pop),
		.full     (q_full),
		.empty    (q_empty),
		.head_err (head_err)
	);

	encp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_err   (head_err),
		.q_pop   (q_pop),
		.kp      (kp_q),
		.ki      (ki_q),
		.kd      (kd_q),
		.base    (base_q),
		.rsp     (rsp)
	);

endmodule
`default_nettype wire

/* rtl/encp_front.sv */
// Front end: accepts requests, keeps wheel counters, forms the tick error.
`timescale 1ns / 1ps
`default_nettype none
module encp_front import encp_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	encp_req_if.sink                     req,
	input  wire logic                    q_full,
	output logic                         q_push,
	output logic signed [ERR_W-1:0]      q_err
);

	logic [COUNT_WIDTH-1:0] right_q;
	logic [COUNT_WIDTH-1:0] left_q;
	logic [COUNT_WIDTH-1:0] diff;
	logic                   accept;
	op_t                    op;

	assign req.ready = !q_full;
	assign accept    = req.valid && req.ready;
	assign op        = op_t'(req.operation);
	assign diff      = left_q - right_q;

	// difference saturated to the 32 bit error range
	generate
		if (COUNT_WIDTH <= ERR_W) begin : g_narrow
			assign q_err = ERR_W'($signed(diff));
		end else begin : g_wide
			logic [COUNT_WIDTH-ERR_W:0] upper;
			logic                       fits;
			assign upper = diff[COUNT_WIDTH-1:ERR_W-1];
			assign fits  = (&upper) || !(|upper);
			assign q_err = fits ? $signed(diff[ERR_W-1:0])
				: (diff[COUNT_WIDTH-1] ? ERR_MIN : ERR_MAX);
		end
	endgenerate

	assign q_push = accept && (op == OP_TICK);

	// encoder counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q <= '0;
			left_q  <= '0;
		end else if (accept) begin
			case (op)
				OP_RIGHT_EDGE: right_q <= req.phase_b ? right_q - 1'b1 : right_q + 1'b1;
				OP_LEFT_EDGE:  left_q  <= req.phase_b ? left_q + 1'b1 : left_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/encp_fifo.sv */
// Short queue of tick errors between front and back.
`timescale 1ns / 1ps
`default_nettype none
module encp_fifo import encp_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	input  wire logic signed [ERR_W-1:0] push_err,
	input  wire logic                    pop,
	output logic                         full,
	output logic                         empty,
	output logic signed [ERR_W-1:0]      head_err
);

	logic signed [ERR_W-1:0] mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]       wr_q;
	logic [QPTR_W-1:0]       rd_q;
	logic [QPTR_W:0]         cnt_q;
	logic                    do_push;
	logic                    do_pop;

	assign full     = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_err = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_err;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop)  rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

/* rtl/encp_back.sv */
// Back end: PID pipeline from queued error to clamped drive levels.
`timescale 1ns / 1ps
`default_nettype none
module encp_back import encp_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    q_empty,
	input  wire logic signed [ERR_W-1:0] q_err,
	output logic                         q_pop,
	input  wire logic [15:0]             kp,
	input  wire logic [15:0]             ki,
	input  wire logic [15:0]             kd,
	input  wire logic [7:0]              base,
	encp_rsp_if.source                   rsp
);

	logic en;

	// stage 1: integral and derivative
	logic                    valid_s1;
	logic signed [31:0]      err_s1;
	logic signed [31:0]      sum_s1;
	logic signed [32:0]      deriv_s1;
	logic signed [31:0]      esum_q;
	logic signed [31:0]      last_q;
	logic signed [32:0]      sum_raw;
	logic signed [31:0]      sum_sat;

	// stage 2: products
	logic                    valid_s2;
	logic signed [31:0]      err_s2;
	logic signed [48:0]      p_s2;
	logic signed [48:0]      i_s2;
	logic signed [49:0]      d_s2;

	// stage 3: accumulate
	logic                    valid_s3;
	logic signed [31:0]      err_s3;
	logic signed [51:0]      acc_s3;

	// output stage
	logic                    out_valid_q;
	logic signed [51:0]      acc_bias;
	logic signed [43:0]      corr;
	logic signed [44:0]      right_sum;
	logic signed [44:0]      left_sum;
	logic [7:0]              right_cl;
	logic [7:0]              left_cl;

	assign en        = !out_valid_q || rsp.ready;
	assign q_pop     = en && !q_empty;
	assign rsp.valid = out_valid_q;

	assign sum_raw = 33'(esum_q) + 33'(q_err);
	assign sum_sat = (sum_raw > 33'(ERR_MAX)) ? ERR_MAX
		: ((sum_raw < 33'(ERR_MIN)) ? ERR_MIN : sum_raw[31:0]);

	// truncate toward zero, then clamp both sides
	assign acc_bias  = acc_s3 + (acc_s3[51] ? 52'sd255 : 52'sd0);
	assign corr      = acc_bias[51:8];
	assign right_sum = $signed({37'd0, base}) + 45'(corr);
	assign left_sum  = $signed({37'd0, base}) - 45'(corr);
	assign right_cl  = right_sum[44] ? 8'd0 : ((right_sum > 45'sd255) ? 8'd255 : right_sum[7:0]);
	assign left_cl   = left_sum[44] ? 8'd0 : ((left_sum > 45'sd255) ? 8'd255 : left_sum[7:0]);

	// control state and integrator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			esum_q      <= '0;
			last_q      <= '0;
		end else if (en) begin
			valid_s1    <= !q_empty;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
			if (!q_empty) begin
				esum_q <= sum_sat;
				last_q <= q_err;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			err_s1   <= q_err;
			sum_s1   <= sum_sat;
			deriv_s1 <= 33'(q_err) - 33'(last_q);

			err_s2 <= err_s1;
			p_s2   <= $signed({1'b0, kp}) * err_s1;
			i_s2   <= $signed({1'b0, ki}) * sum_s1;
			d_s2   <= $signed({1'b0, kd}) * deriv_s1;

			err_s3 <= err_s2;
			acc_s3 <= 52'(p_s2) + 52'(i_s2) + 52'(d_s2);

			rsp.right_drive      <= right_cl;
			rsp.left_drive       <= left_cl;
			rsp.count_difference <= err_s3;
		end
	end

endmodule
`default_nettype wire

/* dv/tb_encoder_pid_differential_drive_core.sv */
// Testbench: random and directed checking of the encoder PID drive balancer.
`timescale 1ns / 1ps
module tb_encoder_pid_differential_drive_core;
	import encp_pkg::*;

	localparam int CLK_HALF       = 10;
	localparam int RESET_CYCLES   = 8;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLDOFF_CYCLES = 150;
	localparam int QUIET_LIMIT    = 4000;
	localparam int IDLE_PCT       = 34;

	// operation code the block must ignore
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0]         right_drive;
		logic [7:0]         left_drive;
		logic signed [31:0] count_difference;
	} drive_t;

	// Tracks encoder counts and PID state, predicts the drive of each tick.
	class wheel_balance_sb;
		logic [15:0] kp, ki, kd;
		logic [7:0]  base;
		logic [31:0] right_pos, left_pos;
		int          err_sum, last_err;
		drive_t      pending_drives[$];
		int          mismatches, drives_checked, ticks_seen, requests_seen;

		function new();
			kp = KP_RESET;
			ki = KI_RESET;
			kd = KD_RESET;
			base = BASE_RESET;
			right_pos = '0;
			left_pos = '0;
			err_sum = 0;
			last_err = 0;
		endfunction

		function void set_register(logic [7:0] idx, logic [15:0] data);
			case (idx)
				REG_KP:   kp = data;
				REG_KI:   ki = data;
				REG_KD:   kd = data;
				REG_BASE: base = data[7:0];
				default:  ;
			endcase
		endfunction

		function logic [7:0] clamp_duty(longint v);
			if (v < 0)
				return 8'd0;
			if (v > 255)
				return 8'd255;
			return 8'(v);
		endfunction

		// one PID evaluation per tick
		function drive_t predict_tick();
			longint err, sum, acc, corr;
			drive_t res;
			err = longint'($signed(left_pos - right_pos));
			sum = longint'(err_sum) + err;
			if (sum > longint'(ERR_MAX))
				sum = longint'(ERR_MAX);
			else if (sum < longint'(ERR_MIN))
				sum = longint'(ERR_MIN);
			acc = longint'(kp) * err + longint'(ki) * sum
				+ longint'(kd) * (err - longint'(last_err));
			corr = acc / 256;   // truncates toward zero
			err_sum = int'(sum);
			last_err = int'(err);
			res.right_drive = clamp_duty(longint'(base) + corr);
			res.left_drive = clamp_duty(longint'(base) - corr);
			res.count_difference = err[31:0];
			return res;
		endfunction

		function void note_request(logic [1:0] op, logic b);
			requests_seen++;
			case (op)
				OP_RIGHT_EDGE: right_pos = b ? right_pos - 1 : right_pos + 1;
				OP_LEFT_EDGE:  left_pos = b ? left_pos + 1 : left_pos - 1;
				OP_TICK: begin
					ticks_seen++;
					pending_drives.push_back(predict_tick());
				end
				default: ;
			endcase
		endfunction

		function void check_drive(drive_t got);
			drive_t want;
			if (pending_drives.size() == 0) begin
				$error("unexpected drive response: right_drive %0d left_drive %0d count_difference %0d",
					got.right_drive, got.left_drive, got.count_difference);
				mismatches++;
				return;
			end
			want = pending_drives.pop_front();
			drives_checked++;
			if (got.right_drive !== want.right_drive) begin
				$error("right_drive: expected %0d, got %0d", want.right_drive, got.right_drive);
				mismatches++;
			end
			if (got.left_drive !== want.left_drive) begin
				$error("left_drive: expected %0d, got %0d", want.left_drive, got.left_drive);
				mismatches++;
			end
			if (got.count_difference !== want.count_difference) begin
				$error("count_difference: expected %0d, got %0d",
					want.count_difference, got.count_difference);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   req_idle_pct = IDLE_PCT;
	int   rsp_idle_pct = IDLE_PCT;
	bit   holdoff_pending;
	bit   drift_up;
	int   quiet_cycles;
	int   writes_done;

	wheel_balance_sb balance = new();

	encp_req_if req_ch ();
	encp_rsp_if rsp_ch ();
	encp_cfg_if cfg_ch ();

	encoder_pid_differential_drive_core #(.COUNT_WIDTH(32)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	// clock
	always begin
		clk = 1'b0;
		#(CLK_HALF);
		clk = 1'b1;
		#(CLK_HALF);
	end

	// response side ready, with random stalls and an occasional long hold-off
	initial begin
		int holdoff_left;
		holdoff_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_left > 0) begin
				holdoff_left--;
				rsp_ch.ready <= 1'b0;
			end else if (holdoff_pending) begin
				holdoff_pending = 1'b0;
				holdoff_left = HOLDOFF_CYCLES - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
			end
		end
	end

	// response check
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			balance.check_drive({rsp_ch.right_drive, rsp_ch.left_drive,
				rsp_ch.count_difference});
	end

	// watchdog on cycles with no accepted transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout after %0d quiet cycles", quiet_cycles);
				$display("FAIL encoder_pid_differential_drive_core");
				$finish;
			end
		end
	end

	// one request, with random idle cycles ahead of it
	task automatic send_request(input logic [1:0] op, input logic b);
		@(negedge clk);
		while ($urandom_range(99) < req_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.phase_b <= b;
		do
			@(posedge clk);
		while (!req_ch.ready);
		balance.note_request(op, b);
	endtask

	task automatic write_register(input logic [7:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		balance.set_register(idx, data);
		writes_done++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// stop requests, wait for every drive response, let the pipeline settle
	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (balance.pending_drives.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// all four registers plus one write to an index past the list
	task automatic apply_setting(input logic [15:0] kp, input logic [15:0] ki,
		input logic [15:0] kd, input logic [15:0] base);
		write_register(REG_KP, kp);
		write_register(REG_KI, ki);
		write_register(REG_KD, kd);
		write_register(REG_BASE, base);
		write_register(REG_BASE + 8'($urandom_range(1, 252)), 16'($urandom));
	endtask

	function automatic logic [15:0] pick_gain();
		if ($urandom_range(3) == 0)
			return 16'($urandom);
		return 16'($urandom_range(0, 1023));
	endfunction

	// sign handling, truncation toward zero, both edge directions, ignored code
	task automatic run_directed();
		send_request(OP_TICK, 1'b0);
		repeat (3) send_request(OP_LEFT_EDGE, 1'b1);
		send_request(OP_TICK, 1'b1);
		send_request(OP_RIGHT_EDGE, 1'b0);
		send_request(OP_TICK, 1'b0);
		repeat (3) send_request(OP_RIGHT_EDGE, 1'b1);
		send_request(OP_TICK, 1'b0);
		repeat (8) send_request(OP_LEFT_EDGE, 1'b0);
		send_request(OP_TICK, 1'b0);
		send_request(OP_UNUSED, 1'b0);
		send_request(OP_UNUSED, 1'b1);
		send_request(OP_TICK, 1'b1);
	endtask

	// edges lean toward a drifting direction so the error swings wide
	task automatic run_random(input int count, input int tick_pct);
		logic [1:0] op;
		logic b;
		int roll;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			if ($urandom_range(39) == 0)
				drift_up = !drift_up;
			if (roll < 3) begin
				op = OP_UNUSED;
				b = 1'($urandom_range(1));
			end else if (roll < 3 + tick_pct) begin
				op = OP_TICK;
				b = 1'($urandom_range(1));
			end else begin
				op = $urandom_range(1) ? OP_LEFT_EDGE : OP_RIGHT_EDGE;
				b = ($urandom_range(99) < 70) ? drift_up : !drift_up;
			end
			send_request(op, b);
		end
	endtask

	// main sequence
	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_RIGHT_EDGE;
		req_ch.phase_b = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_KP;
		cfg_ch.data = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset gains
		run_directed();
		wait_idle();

		// every gain at full scale, top base
		apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF);
		run_random(200, 25);
		wait_idle();

		// all zero; upper data bits of the base write are dropped
		apply_setting(16'h0000, 16'h0000, 16'h0000, {8'($urandom), 8'h00});
		run_random(150, 25);
		wait_idle();

		// unity proportional gain, no idling on either side
		req_idle_pct = 0;
		rsp_idle_pct = 0;
		apply_setting(16'd256, 16'd0, 16'd0, 16'd128);
		run_random(200, 25);
		wait_idle();
		rsp_idle_pct = IDLE_PCT;

		// back pressure: receiver holds off while ticks keep coming
		apply_setting(16'd154, 16'd16, 16'd512, 16'd100);
		holdoff_pending = 1'b1;
		run_random(200, 60);
		wait_idle();
		req_idle_pct = IDLE_PCT;

		// random settings
		for (int p = 0; p < 4; p++) begin
			apply_setting(pick_gain(), pick_gain(), pick_gain(), 16'($urandom));
			run_random(225, 25);
			wait_idle();
		end

		$display("covered %0d requests, %0d ticks, %0d drive responses checked",
			balance.requests_seen, balance.ticks_seen, balance.drives_checked);
		$display("over %0d register writes in nine gain settings, one with a long hold-off",
			writes_done);
		if (balance.mismatches == 0)
			$display("PASS encoder_pid_differential_drive_core");
		else
			$display("FAIL encoder_pid_differential_drive_core");
		$finish;
	end

endmodule
